@@ hdl/seol_pkg.sv @@
package seol_pkg;

  // register indexes of the configuration port
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] REG_SE_WIDTH     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SE_HEIGHT    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SE_DEPTH     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_X     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Y     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ORIGIN_Z     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_WIDTH  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_IMAGE_HEIGHT = 3'd7;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 128;
  localparam int unsigned OffsetW  = 43;
  localparam int unsigned EntryW   = 24;

  typedef struct packed {
    logic take;        // input transfer this cycle
    logic mul_first;   // w*dy and w*h
    logic mul_second;  // w*h*dz
    logic add;         // final offset sum
    logic emit_margin; // output shows the margin record
  } seol_cmd_t;

  typedef struct packed {
    logic in_nonzero;   // mask pixel at the input is set
    logic elem_end;     // current pixel closes the element
    logic margin_pend;  // accepted pixel closed the element
  } seol_sts_t;

endpackage

@@ hdl/seol_ctrl.sv @@
module seol_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  seol_pkg::seol_sts_t sts_i,
  output seol_pkg::seol_cmd_t cmd_o
);
  import seol_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL1   = 6'b000010,
    ST_MUL2   = 6'b000100,
    ST_ADD    = 6'b001000,
    ST_ENTRY  = 6'b010000,
    ST_MARGIN = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   take;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign take        = in_ready_o && in_valid_i;
  assign out_valid_o = (state_q == ST_ENTRY) || (state_q == ST_MARGIN);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (sts_i.in_nonzero) begin
            state_d = ST_MUL1;
          end else if (sts_i.elem_end) begin
            state_d = ST_MARGIN;
          end
        end
      end
      ST_MUL1:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_ADD;
      ST_ADD:   state_d = ST_ENTRY;
      ST_ENTRY: begin
        if (out_ready_i) begin
          state_d = sts_i.margin_pend ? ST_MARGIN : ST_IDLE;
        end
      end
      ST_MARGIN: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o.take        = take;
  assign cmd_o.mul_first   = (state_q == ST_MUL1);
  assign cmd_o.mul_second  = (state_q == ST_MUL2);
  assign cmd_o.add         = (state_q == ST_ADD);
  assign cmd_o.emit_margin = (state_q == ST_MARGIN);

endmodule

@@ hdl/seol_dp.sv @@
module seol_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [seol_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [seol_pkg::CfgDataW-1:0]      cfg_data_i,
  input  logic [seol_pkg::InDataW-1:0]       in_data_i,
  input  seol_pkg::seol_cmd_t                cmd_i,
  output seol_pkg::seol_sts_t                sts_o,
  output logic [seol_pkg::OutDataW-1:0]      out_data_o,
  output logic                               out_user_o,
  output logic                               out_last_o
);
  import seol_pkg::*;

  // configuration
  logic [7:0]        se_w_q, se_h_q, se_d_q;
  logic signed [8:0] ox_q, oy_q, oz_q;
  logic [15:0]       img_w_q, img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      se_w_q  <= 8'd3;
      se_h_q  <= 8'd3;
      se_d_q  <= 8'd1;
      ox_q    <= 9'sd1;
      oy_q    <= 9'sd1;
      oz_q    <= 9'sd0;
      img_w_q <= 16'd256;
      img_h_q <= 16'd256;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SE_WIDTH:     se_w_q  <= cfg_data_i[7:0];
        REG_SE_HEIGHT:    se_h_q  <= cfg_data_i[7:0];
        REG_SE_DEPTH:     se_d_q  <= cfg_data_i[7:0];
        REG_ORIGIN_X:     ox_q    <= cfg_data_i[8:0];
        REG_ORIGIN_Y:     oy_q    <= cfg_data_i[8:0];
        REG_ORIGIN_Z:     oz_q    <= cfg_data_i[8:0];
        REG_IMAGE_WIDTH:  img_w_q <= cfg_data_i;
        REG_IMAGE_HEIGHT: img_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // position counters; a zero dimension counts as one
  logic [7:0]  col_q, row_q, pl_q;
  logic [EntryW-1:0] entries_q, entries_inc;
  logic [7:0]  lim_x, lim_y, lim_z;
  logic        col_end, row_end, pl_end, elem_end, nonzero;

  assign lim_x    = (se_w_q == 8'd0) ? 8'd0 : se_w_q - 8'd1;
  assign lim_y    = (se_h_q == 8'd0) ? 8'd0 : se_h_q - 8'd1;
  assign lim_z    = (se_d_q == 8'd0) ? 8'd0 : se_d_q - 8'd1;
  assign col_end  = col_q >= lim_x;
  assign row_end  = row_q >= lim_y;
  assign pl_end   = pl_q >= lim_z;
  assign elem_end = col_end && row_end && pl_end;
  assign nonzero  = (in_data_i[7:0] != 8'd0);
  assign entries_inc = entries_q + EntryW'(nonzero);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      pl_q      <= '0;
      entries_q <= '0;
    end else if (cmd_i.take) begin
      entries_q <= elem_end ? '0 : entries_inc;
      if (col_end) begin
        col_q <= '0;
        if (row_end) begin
          row_q <= '0;
          pl_q  <= pl_end ? 8'd0 : pl_q + 8'd1;
        end else begin
          row_q <= row_q + 8'd1;
        end
      end else begin
        col_q <= col_q + 8'd1;
      end
    end
  end

  // item snapshot
  logic signed [9:0]  dx_q, dy_q, dz_q;
  logic [7:0]         weight_q;
  logic [EntryW-1:0]  idx_q, mcount_q;
  logic               pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else if (cmd_i.take) begin
      pend_q <= elem_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      dx_q     <= $signed({2'b00, col_q}) - $signed({ox_q[8], ox_q});
      dy_q     <= $signed({2'b00, row_q}) - $signed({oy_q[8], oy_q});
      dz_q     <= $signed({2'b00, pl_q}) - $signed({oz_q[8], oz_q});
      weight_q <= in_data_i[15:8];
      idx_q    <= entries_q;
      mcount_q <= entries_inc;
    end
  end

  // offset = dx + w*dy + (w*h)*dz over three steps
  logic signed [26:0]        wdy_q;
  logic [31:0]               wh_q;
  logic signed [OffsetW-1:0] whdz_q, off_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_first) begin
      wdy_q <= $signed({1'b0, img_w_q}) * dy_q;
      wh_q  <= img_w_q * img_h_q;
    end
    if (cmd_i.mul_second) begin
      whdz_q <= $signed({1'b0, wh_q}) * dz_q;
    end
    if (cmd_i.add) begin
      off_q <= whdz_q + OffsetW'(wdy_q) + OffsetW'(dx_q);
    end
  end

  // border margins from the configuration
  logic [7:0]  m_left, m_top, m_front;
  logic [8:0]  m_right, m_bottom, m_back;
  logic [7:0]  nx, ny, nz;
  logic signed [10:0] far_x, far_y, far_z;

  assign nx = (se_w_q == 8'd0) ? 8'd1 : se_w_q;
  assign ny = (se_h_q == 8'd0) ? 8'd1 : se_h_q;
  assign nz = (se_d_q == 8'd0) ? 8'd1 : se_d_q;
  assign far_x = $signed({3'b000, lim_x}) - 11'(ox_q);
  assign far_y = $signed({3'b000, lim_y}) - 11'(oy_q);
  assign far_z = $signed({3'b000, lim_z}) - 11'(oz_q);

  assign m_left   = ox_q[8] ? 8'd0 : ox_q[7:0];
  assign m_top    = oy_q[8] ? 8'd0 : oy_q[7:0];
  assign m_front  = oz_q[8] ? 8'd0 : oz_q[7:0];
  assign m_right  = ($signed(ox_q) >= $signed({1'b0, nx})) ? 9'd0 : far_x[8:0];
  assign m_bottom = ($signed(oy_q) >= $signed({1'b0, ny})) ? 9'd0 : far_y[8:0];
  assign m_back   = ($signed(oz_q) >= $signed({1'b0, nz})) ? 9'd0 : far_z[8:0];

  always_comb begin
    out_data_o = '0;
    if (cmd_i.emit_margin) begin
      out_data_o[74:51]   = mcount_q;
      out_data_o[82:75]   = m_left;
      out_data_o[91:83]   = m_right;
      out_data_o[99:92]   = m_top;
      out_data_o[108:100] = m_bottom;
      out_data_o[116:109] = m_front;
      out_data_o[125:117] = m_back;
    end else begin
      out_data_o[42:0]    = off_q;
      out_data_o[50:43]   = weight_q;
      out_data_o[74:51]   = idx_q;
    end
  end

  assign out_user_o = cmd_i.emit_margin;
  assign out_last_o = cmd_i.emit_margin;

  assign sts_o.in_nonzero  = nonzero;
  assign sts_o.elem_end    = elem_end;
  assign sts_o.margin_pend = pend_q;

endmodule

@@ hdl/structuring_element_offset_list_unit.sv @@
// Structuring-element offset list unit.
// Mask pixels of a 3-D element enter on the s_axis channel in raster order
// (column fastest, then row, then plane), with their weights. Column, row and
// plane are counted inside. Each set pixel yields an offset entry on m_axis
// (tuser low): offset from the origin, weight and running entry index. The
// last pixel of the element yields a margin record (tuser and tlast high)
// carrying the six clamped border margins and the entry count.
// The user must write the configuration registers through cfg_we_i/cfg_idx_i/
// cfg_data_i only while the block is idle; the block itself does not enforce it.
// One pixel is handled at a time. A clear pixel yields no entry. A set pixel
// goes through the multiply sequence (w*dy and w*h, then w*h*dz, then the sum)
// and then its entry is presented on m_axis; the next pixel can be taken in
// the cycle after the output transfer. A pixel that closes the element is
// followed by its margin record before the next pixel is taken.
// While the receiver holds tready low the result stays on the port unchanged
// and s_axis_tready_o stays low. Reset loads the default configuration
// (3x3x1 mask, origin 1,1,0, 256x256 image) and clears all counters.
module structuring_element_offset_list_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [seol_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [seol_pkg::CfgDataW-1:0]     cfg_data_i,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // mask_value[7:0], weight_in[15:8]
  input  logic [seol_pkg::InDataW-1:0]      s_axis_tdata_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // offset[42:0], weight_out[50:43], entry_index[74:51], margin_left[82:75],
  // margin_right[91:83], margin_top[99:92], margin_bottom[108:100],
  // margin_front[116:109], margin_back[125:117], zero[127:126]
  output logic [seol_pkg::OutDataW-1:0]     m_axis_tdata_o,
  // is_margins
  output logic                              m_axis_tuser_o,
  output logic                              m_axis_tlast_o
);
  import seol_pkg::*;

  seol_cmd_t cmd;
  seol_sts_t sts;

  seol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  seol_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (s_axis_tdata_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (m_axis_tdata_o),
    .out_user_o (m_axis_tuser_o),
    .out_last_o (m_axis_tlast_o)
  );

endmodule

@@ hdl/seol_checker.sv @@
module seol_assertions (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [seol_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic                          m_axis_tuser_o,
  input logic                          m_axis_tlast_o
);

  // one pixel in flight: no input transfer while a result is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !s_axis_tready_o)
    else $error("input taken while a result is pending");

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  // an offset entry carries no margins, a margin record no offset or weight
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |->
      (m_axis_tuser_o ? (m_axis_tdata_o[50:0] == '0)
                      : (m_axis_tdata_o[127:75] == '0)))
    else $error("result fields mixed");

  // last marks exactly the margin record
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tlast_o == m_axis_tuser_o))
    else $error("tlast does not match record kind");

  // an offset entry is never followed by another offset entry without a new input
  a_entry_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tready_i && !m_axis_tuser_o |=>
      !(m_axis_tvalid_o && !m_axis_tuser_o))
    else $error("offset entry repeated");

endmodule

bind structuring_element_offset_list_unit seol_assertions u_seol_assertions (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

@@ verif/seol_checker.sv @@
module seol_checker
  import seol_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  // mask_value[7:0], weight_in[15:8]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  // offset[42:0], weight_out[50:43], entry_index[74:51], margin_left[82:75],
  // margin_right[91:83], margin_top[99:92], margin_bottom[108:100],
  // margin_front[116:109], margin_back[125:117], zero[127:126]
  input  logic [OutDataW-1:0] m_axis_tdata_i,
  // is_margins
  input  logic                m_axis_tuser_i,
  input  logic                m_axis_tlast_i,
  output int                  mismatches_o,
  output int                  recs_waiting_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              is_margins;
    logic [OffsetW-1:0] offset;
    logic [7:0]        weight;
    logic [EntryW-1:0] entry_idx;
    logic [7:0]        m_left;
    logic [8:0]        m_right;
    logic [7:0]        m_top;
    logic [8:0]        m_bottom;
    logic [7:0]        m_front;
    logic [8:0]        m_back;
    logic              last;
  } seol_rec_t;

  seol_rec_t expected_recs[$];

  // shadow of the configuration registers
  logic [7:0]        se_w, se_h, se_d;
  logic signed [8:0] org_x, org_y, org_z;
  logic [15:0]       img_w, img_h;

  // raster position inside the element and entries so far
  logic [7:0]        col_cnt, row_cnt, plane_cnt;
  logic [EntryW-1:0] entry_cnt;

  initial mismatches_o = 0;

  task automatic report_error(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatches_o++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report_error($sformatf("%s mismatch: got %0h, expected %0h", name, got, want));
  endtask

  function automatic longint clamp_low(input longint org);
    return (org < 0) ? 0 : org;
  endfunction

  function automatic longint clamp_high(input longint dim, input longint org);
    return (org >= dim) ? 0 : dim - 1 - org;
  endfunction

  task automatic predict_pixel(input logic [7:0] mask, input logic [7:0] weight);
    longint nx, ny, nz, ox, oy, oz, w, h, off_val;
    bit col_end, row_end, plane_end;
    seol_rec_t rec;
    nx = (se_w == 0) ? 1 : longint'(se_w);
    ny = (se_h == 0) ? 1 : longint'(se_h);
    nz = (se_d == 0) ? 1 : longint'(se_d);
    ox = longint'(org_x);
    oy = longint'(org_y);
    oz = longint'(org_z);
    w = longint'(img_w);
    h = longint'(img_h);
    // a counter past a shrunken limit counts as sitting at the end
    col_end = longint'(col_cnt) >= nx - 1;
    row_end = longint'(row_cnt) >= ny - 1;
    plane_end = longint'(plane_cnt) >= nz - 1;

    if (mask != 0) begin
      rec = '{default: '0};
      off_val = (longint'(col_cnt) - ox) + w * (longint'(row_cnt) - oy)
              + w * h * (longint'(plane_cnt) - oz);
      rec.offset = off_val[OffsetW-1:0];
      rec.weight = weight;
      rec.entry_idx = entry_cnt;
      entry_cnt++;
      expected_recs.push_back(rec);
    end

    if (col_end) begin
      col_cnt = '0;
      if (row_end) begin
        row_cnt = '0;
        plane_cnt = plane_end ? 8'd0 : plane_cnt + 8'd1;
      end else begin
        row_cnt++;
      end
    end else begin
      col_cnt++;
    end

    if (col_end && row_end && plane_end) begin
      rec = '{default: '0};
      rec.is_margins = 1'b1;
      rec.entry_idx = entry_cnt;
      rec.m_left = 8'(clamp_low(ox));
      rec.m_right = 9'(clamp_high(nx, ox));
      rec.m_top = 8'(clamp_low(oy));
      rec.m_bottom = 9'(clamp_high(ny, oy));
      rec.m_front = 8'(clamp_low(oz));
      rec.m_back = 9'(clamp_high(nz, oz));
      rec.last = 1'b1;
      entry_cnt = '0;
      expected_recs.push_back(rec);
    end
  endtask

  task automatic check_output();
    seol_rec_t want;
    if (expected_recs.size() == 0) begin
      report_error($sformatf("unexpected result, tdata %h", m_axis_tdata_i));
    end else begin
      want = expected_recs.pop_front();
      check_field("is_margins", m_axis_tuser_i, want.is_margins);
      check_field("offset", m_axis_tdata_i[42:0], want.offset);
      check_field("weight_out", m_axis_tdata_i[50:43], want.weight);
      check_field("entry_index", m_axis_tdata_i[74:51], want.entry_idx);
      check_field("margin_left", m_axis_tdata_i[82:75], want.m_left);
      check_field("margin_right", m_axis_tdata_i[91:83], want.m_right);
      check_field("margin_top", m_axis_tdata_i[99:92], want.m_top);
      check_field("margin_bottom", m_axis_tdata_i[108:100], want.m_bottom);
      check_field("margin_front", m_axis_tdata_i[116:109], want.m_front);
      check_field("margin_back", m_axis_tdata_i[125:117], want.m_back);
      check_field("padding", m_axis_tdata_i[127:126], 0);
      check_field("last", m_axis_tlast_i, want.last);
    end
  endtask

  task automatic apply_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    case (idx)
      REG_SE_WIDTH:     se_w = data[7:0];
      REG_SE_HEIGHT:    se_h = data[7:0];
      REG_SE_DEPTH:     se_d = data[7:0];
      REG_ORIGIN_X:     org_x = data[8:0];
      REG_ORIGIN_Y:     org_y = data[8:0];
      REG_ORIGIN_Z:     org_z = data[8:0];
      REG_IMAGE_WIDTH:  img_w = data;
      REG_IMAGE_HEIGHT: img_h = data;
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      se_w = 8'd3;
      se_h = 8'd3;
      se_d = 8'd1;
      org_x = 9'sd1;
      org_y = 9'sd1;
      org_z = 9'sd0;
      img_w = 16'd256;
      img_h = 16'd256;
      col_cnt = '0;
      row_cnt = '0;
      plane_cnt = '0;
      entry_cnt = '0;
      expected_recs.delete();
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) check_output();
      if (s_axis_tvalid_i && s_axis_tready_i) predict_pixel(s_axis_tdata_i[7:0],
                                                            s_axis_tdata_i[15:8]);
      if (cfg_we_i) apply_write(cfg_idx_i, cfg_data_i);
    end
    recs_waiting_o = expected_recs.size();
  end

endmodule

@@ verif/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import seol_pkg::*;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;
  logic                m_tlast;

  int mismatches;
  int recs_waiting;

  int pixels_sent = 0;
  int elem_size = 9;
  int burst_left = 0;
  bit no_gaps = 1'b0;

  // receiver stall pattern state
  int rx_mode = 0;
  int rx_span = 0;
  int rx_period = 2;
  int rx_duty = 1;
  int rx_tick = 0;

  structuring_element_offset_list_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  seol_checker checker_i (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_i (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_i (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_i  (m_tdata),
    .m_axis_tuser_i  (m_tuser),
    .m_axis_tlast_i  (m_tlast),
    .mismatches_o    (mismatches),
    .recs_waiting_o  (recs_waiting)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_span = $urandom_range(16, 96);
      rx_period = $urandom_range(2, 12);
      rx_duty = $urandom_range(1, rx_period - 1);
      rx_tick = 0;
    end else begin
      rx_span--;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 2) != 0);
      default: m_tready <= ((rx_tick % rx_period) < rx_duty);
    endcase
    rx_tick++;
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= CfgDataW'(val);
    @(posedge clk);
  endtask

  // origins are passed as plain ints and written as 9-bit two's complement
  task automatic apply_config(input int sw, input int sh, input int sd, input int ox,
                              input int oy, input int oz, input int iw, input int ih);
    write_reg(REG_SE_WIDTH, sw);
    write_reg(REG_SE_HEIGHT, sh);
    write_reg(REG_SE_DEPTH, sd);
    write_reg(REG_ORIGIN_X, ox & 'h1FF);
    write_reg(REG_ORIGIN_Y, oy & 'h1FF);
    write_reg(REG_ORIGIN_Z, oz & 'h1FF);
    write_reg(REG_IMAGE_WIDTH, iw);
    write_reg(REG_IMAGE_HEIGHT, ih);
    cfg_we <= 1'b0;
    elem_size = ((sw == 0) ? 1 : sw) * ((sh == 0) ? 1 : sh) * ((sd == 0) ? 1 : sd);
  endtask

  task automatic send_pixel(input logic [7:0] mask, input logic [7:0] weight);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (!no_gaps) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {weight, mask};
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  // clear pixels give no result, so allow the pipeline to drain past the last one
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (recs_waiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic int pick_se_dim();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return 255;
    if (r == 2) return $urandom_range(6, 255);
    return $urandom_range(1, 5);
  endfunction

  function automatic int pick_origin(input int dim);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return ($urandom_range(0, 1) != 0) ? 255 : -255;
    if (r == 1) return -256;
    if (r == 2) return int'($urandom_range(0, 511)) - 256;
    return int'($urandom_range(0, dim)) - 1;
  endfunction

  function automatic int pick_image_dim();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 65535;
    if (r == 2) return 1;
    if (r <= 5) return $urandom_range(0, 65535);
    return $urandom_range(1, 1024);
  endfunction

  task automatic random_phase();
    int sw, sh, sd, n, r;
    logic [7:0] mask;
    wait_idle();
    sw = pick_se_dim();
    sh = pick_se_dim();
    sd = pick_se_dim();
    apply_config(sw, sh, sd, pick_origin(sw), pick_origin(sh), pick_origin(sd),
                 pick_image_dim(), pick_image_dim());
    no_gaps = ($urandom_range(0, 3) == 0);
    // mostly whole elements, otherwise a partial run that leaves counters mid-element
    if (elem_size <= 64 && $urandom_range(0, 6) != 0)
      n = elem_size * $urandom_range(1, 3);
    else
      n = $urandom_range(1, 40);
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 4) mask = 8'd0;
      else if (r == 4) mask = 8'd255;
      else if (r == 5) mask = 8'd1;
      else mask = 8'($urandom_range(1, 255));
      send_pixel(mask, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= REG_SE_WIDTH;
    cfg_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    m_tready <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // one full element under the reset configuration
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd1, 8'd255);
    send_pixel(8'd0, 8'd17);
    send_pixel(8'd128, 8'd170);
    send_pixel(8'd0, 8'd85);
    send_pixel(8'd127, 8'd1);
    send_pixel(8'd2, 8'd128);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd64, 8'd254);

    // single-pixel elements, origins outside the mask, largest image
    wait_idle();
    apply_config(1, 1, 1, 255, -255, -256, 65535, 65535);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd3);
    send_pixel(8'd1, 8'd0);

    // zero mask dimensions count as one, zero image dimensions
    wait_idle();
    apply_config(0, 0, 0, 0, 0, 0, 0, 0);
    send_pixel(8'd9, 8'd77);
    send_pixel(8'd0, 8'd200);

    // widest mask, left partly done
    wait_idle();
    apply_config(255, 255, 255, -255, 255, 255, 1, 65535);
    send_pixel(8'd200, 8'd33);
    send_pixel(8'd0, 8'd44);
    send_pixel(8'd1, 8'd55);
    send_pixel(8'd255, 8'd66);

    // shrink the mask under a column count already past the new width
    wait_idle();
    apply_config(2, 1, 1, -1, 0, 0, 65535, 1);
    send_pixel(8'd3, 8'd99);
    send_pixel(8'd4, 8'd100);
    send_pixel(8'd5, 8'd101);

    // deepest mask with the origin just past the back plane
    wait_idle();
    apply_config(1, 1, 255, 0, 0, 255, 300, 200);
    send_pixel(8'd6, 8'd7);
    send_pixel(8'd0, 8'd8);
    send_pixel(8'd250, 8'd9);

    while (pixels_sent < 1150) random_phase();

    s_tvalid <= 1'b0;
    @(posedge clk);
    while (recs_waiting != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && recs_waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
